// File: src/lbbt_pkg.sv
// Package for the per-label bounding box table.
// Holds the operation codes of the input item. It depends on nothing else.
package lbbt_pkg;

  // Operation carried in the input item's tuser bit.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_READ  = 1'b1;

endpackage

// File: src/label_bounding_box_table.sv
// Per-label bounding box table: one box and present flag for each label value.
// An accepted readout passes the second stage, then loads the output register.
// Throughput: one item per cycle; in_tready drops during the clearing pass and while a
// readout waits in the second stage because the output register holds an untaken item.
// Reset: rst_n is synchronous and active low. After reset a clearing pass writes
// all 2**LABEL_BITS entries, one per cycle (256 entries by default), with in_tready low.
module label_bounding_box_table #(
  parameter int LABEL_BITS = 8,
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst_n,
  // Input channel.
  input  logic in_tvalid,
  output logic in_tready,
  // Fields from bit 0 up: pixel_row, pixel_col, label_value, zero padding.
  input  logic [((2*COORD_BITS+LABEL_BITS+7)/8)*8-1:0] in_tdata,
  // Fields from bit 0 up: op.
  input  logic in_tuser,
  // Result channel.
  output logic out_tvalid,
  input  logic out_tready,
  // Fields from bit 0 up: label_out, box_top, box_left, box_bottom, box_right,
  // zero padding.
  output logic [((4*COORD_BITS+LABEL_BITS+7)/8)*8-1:0] out_tdata,
  // Fields from bit 0 up: present.
  output logic out_tuser
);

  localparam int DEPTH       = 2**LABEL_BITS;
  localparam int OUT_W       = 4*COORD_BITS + LABEL_BITS;
  localparam int OUT_TDATA_W = ((OUT_W+7)/8)*8;

  // One stored entry: present flag and the four box coordinates.
  typedef struct packed {
    logic                  present;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] bottom;
    logic [COORD_BITS-1:0] right;
  } entry_t;

  // Unpack the input item.
  logic [COORD_BITS-1:0] in_row;
  logic [COORD_BITS-1:0] in_col;
  logic [LABEL_BITS-1:0] in_label;
  logic                  in_fire;

  assign in_row   = in_tdata[COORD_BITS-1:0];
  assign in_col   = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_label = in_tdata[2*COORD_BITS+LABEL_BITS-1:2*COORD_BITS];

  // Box store and its registered read port.
  entry_t box_mem [DEPTH];
  entry_t mem_rdata_r;
  logic                  mem_we;
  logic [LABEL_BITS-1:0] mem_waddr;
  entry_t                mem_wdata;

  // Clearing pass after reset.
  logic                  clearing_r;
  logic [LABEL_BITS-1:0] clr_addr_r;

  // Second stage: the item whose entry is being read back.
  logic                  s1_valid_r;
  logic                  s1_op_r;
  logic [COORD_BITS-1:0] s1_row_r;
  logic [COORD_BITS-1:0] s1_col_r;
  logic [LABEL_BITS-1:0] s1_label_r;

  // Forwarding of a write-back to the same entry read in the same cycle.
  logic   fwd_r;
  entry_t fwd_ent_r;

  // Output register.
  logic                   out_valid_r;
  logic                   out_present_r;
  logic [OUT_W-1:0]       out_payload_r;

  logic   s1_stall;
  logic   s1_adv;
  logic   s1_wr;
  logic   s1_lab_nz;
  entry_t s1_ent;
  entry_t s1_new_ent;
  logic   s1_present;

  // Handshake: a readout waits while the output register is full and stalled.
  assign s1_stall  = s1_valid_r && (s1_op_r == lbbt_pkg::OP_READ) &&
                     out_valid_r && !out_tready;
  assign s1_adv    = s1_valid_r && !s1_stall;
  assign in_tready = !clearing_r && !s1_stall;
  assign in_fire   = in_tvalid && in_tready;

  // Merge the stored entry with the pixel, or clear it for a readout.
  assign s1_lab_nz  = (s1_label_r != '0);
  assign s1_ent     = fwd_r ? fwd_ent_r : mem_rdata_r;
  assign s1_present = s1_ent.present && s1_lab_nz;
  assign s1_wr      = (s1_op_r == lbbt_pkg::OP_READ) || s1_lab_nz;

  always_comb begin
    s1_new_ent = '0;
    if (s1_op_r == lbbt_pkg::OP_PIXEL) begin
      if (!s1_ent.present) begin
        s1_new_ent.present = 1'b1;
        s1_new_ent.top     = s1_row_r;
        s1_new_ent.bottom  = s1_row_r;
        s1_new_ent.left    = s1_col_r;
        s1_new_ent.right   = s1_col_r;
      end else begin
        s1_new_ent.present = 1'b1;
        s1_new_ent.top     = (s1_row_r < s1_ent.top)    ? s1_row_r : s1_ent.top;
        s1_new_ent.bottom  = (s1_row_r > s1_ent.bottom) ? s1_row_r : s1_ent.bottom;
        s1_new_ent.left    = (s1_col_r < s1_ent.left)   ? s1_col_r : s1_ent.left;
        s1_new_ent.right   = (s1_col_r > s1_ent.right)  ? s1_col_r : s1_ent.right;
      end
    end
  end

  // Single write port, shared by the clearing pass and the write-back.
  assign mem_we    = clearing_r || (s1_adv && s1_wr);
  assign mem_waddr = clearing_r ? clr_addr_r : s1_label_r;
  assign mem_wdata = clearing_r ? entry_t'('0) : s1_new_ent;

  // Memory: read on accept, write-back from the second stage.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      box_mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      mem_rdata_r <= box_mem[in_label];
    end
  end

  // Clearing pass control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Second stage and forwarding registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
      fwd_r      <= s1_adv && s1_wr && (s1_label_r == in_label);
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_tuser;
      s1_row_r   <= in_row;
      s1_col_r   <= in_col;
      s1_label_r <= in_label;
      fwd_ent_r  <= s1_new_ent;
    end
  end

  // Output register: loaded by a readout leaving the second stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && (s1_op_r == lbbt_pkg::OP_READ)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (s1_op_r == lbbt_pkg::OP_READ)) begin
      out_present_r <= s1_present;
      if (s1_present) begin
        out_payload_r <= {s1_ent.right, s1_ent.bottom, s1_ent.left, s1_ent.top,
                          s1_label_r};
      end else begin
        out_payload_r <= {{(4*COORD_BITS){1'b0}}, s1_label_r};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_present_r;
  assign out_tdata  = OUT_TDATA_W'(out_payload_r);

endmodule

// File: src/lbbt_checker.sv
// Port-level checks for the per-label bounding box table.
// Bound to label_bounding_box_table; uses only the top level's ports.
module lbbt_checker #(
  parameter int LABEL_BITS = 8,
  parameter int COORD_BITS = 12
) (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((4*COORD_BITS+LABEL_BITS+7)/8)*8-1:0] out_tdata,
  input logic out_tuser
);

  localparam int OUT_W = 4*COORD_BITS + LABEL_BITS;

  logic [LABEL_BITS-1:0] o_label;
  logic [COORD_BITS-1:0] o_top;
  logic [COORD_BITS-1:0] o_left;
  logic [COORD_BITS-1:0] o_bottom;
  logic [COORD_BITS-1:0] o_right;

  assign o_label  = out_tdata[LABEL_BITS-1:0];
  assign o_top    = out_tdata[LABEL_BITS+COORD_BITS-1:LABEL_BITS];
  assign o_left   = out_tdata[LABEL_BITS+2*COORD_BITS-1:LABEL_BITS+COORD_BITS];
  assign o_bottom = out_tdata[LABEL_BITS+3*COORD_BITS-1:LABEL_BITS+2*COORD_BITS];
  assign o_right  = out_tdata[OUT_W-1:LABEL_BITS+3*COORD_BITS];

  // After a reset edge the block is clearing and holds no result.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !in_tready))
    else $error("busy or output valid right after reset");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped while stalled");

  // The background label never reports present.
  a_bg_absent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (o_label == '0)) |-> !out_tuser)
    else $error("background label reported present");

  // An absent entry reports an all-zero box.
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[OUT_W-1:LABEL_BITS] == '0))
    else $error("absent entry with nonzero box");

  // A present box is well ordered.
  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> ((o_top <= o_bottom) && (o_left <= o_right)))
    else $error("present box with inverted edges");

endmodule

bind label_bounding_box_table lbbt_checker #(
  .LABEL_BITS(LABEL_BITS),
  .COORD_BITS(COORD_BITS)
) u_lbbt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
